// ===== rtl/nmea_sentence_ring_framer_core_assert.svh =====
// assertion macros for the sentence ring framer
`ifndef NMEA_SENTENCE_RING_FRAMER_CORE_ASSERT_SVH
`define NMEA_SENTENCE_RING_FRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define NSRF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nsrf assertion failed");
// condition in one cycle implies a condition in the next cycle
`define NSRF_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("nsrf assertion failed");
`else
`define NSRF_ASSERT(lbl, clk, rst_n, prop)
`define NSRF_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif

`endif

// ===== rtl/nsrf_pkg.sv =====
`default_nettype none

package nsrf_pkg;

  localparam int unsigned SlotsDef     = 8;
  localparam int unsigned MsgMaxLenDef = 128;

  localparam logic [7:0] CharStart = 8'h24;  // '$'
  localparam logic [7:0] CharLf    = 8'h0A;  // line feed

  // reply kind codes
  typedef enum logic [1:0] {
    KIND_RX_STATUS  = 2'd0,
    KIND_MSG_BYTES  = 2'd1,
    KIND_RING_EMPTY = 2'd2,
    KIND_EMPTY_SLOT = 2'd3
  } nsrf_kind_e;

  // classified command from the front to the back
  typedef struct packed {
    logic       is_read;
    logic       is_start;
    logic       is_lf;
    logic [7:0] data;
    logic       err;
  } nsrf_cmd_t;

  // one result beat
  typedef struct packed {
    nsrf_kind_e kind;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] bytes_here;
    logic [7:0] msg_length;
    logic       had_error;
    logic       dropped;
    logic       full;
    logic       last;
  } nsrf_res_t;

endpackage

`default_nettype wire

// ===== rtl/nmea_sentence_ring_framer_core.sv =====
// receive beat: status via queue, output register; one per cycle unless output or read stalls
// read beat: first result via queue, pop, length lookup, byte fetch, output register,
//   then one result of up to two bytes after each further registered byte store read
// rst_ni is asynchronous, active low: clears slot pointers, full and skip flags and the queue
// the byte store is not reset and needs no clearing pass: only written bytes are ever read
`default_nettype none

module nmea_sentence_ring_framer_core
  import nsrf_pkg::*;
#(
  parameter int unsigned SLOTS       = SlotsDef,     // number of message slots in the ring
  parameter int unsigned MSG_MAX_LEN = MsgMaxLenDef  // bytes per slot
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], rx_error[8], zero fill
  input  logic        s_axis_tuser,   // operation
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // byte_first[7:0], byte_second[15:8], bytes_here[17:16],
                                      // msg_length[25:18], msg_had_error[26],
                                      // byte_dropped[27], ring_full[28], zero fill
  output logic [1:0]  m_axis_tuser,   // reply_kind
  output logic        m_axis_tlast    // last
);

  nsrf_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_ready;
  nsrf_res_t res;

  // front: takes beats, classifies start and line feed, short queue
  nsrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_err_i    (s_axis_tdata[8]),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // back: framing state, slot ring, byte store, message streaming, output register
  nsrf_back #(
    .SLOTS       (SLOTS),
    .MSG_MAX_LEN (MSG_MAX_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  // pack the result beat, lowest field first
  assign m_axis_tdata = {3'b000, res.full, res.dropped, res.had_error, res.msg_length,
                         res.bytes_here, res.byte_second, res.byte_first};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== rtl/nsrf_front.sv =====
`default_nettype none

module nsrf_front
  import nsrf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      in_op_i,
  input  logic [7:0] in_byte_i,
  input  logic      in_err_i,
  output logic      cmd_valid_o,
  output nsrf_cmd_t cmd_o,
  input  logic      cmd_ready_i
);

  nsrf_cmd_t   q_mem [2];
  logic        wptr_q, wptr_d;
  logic        rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  nsrf_cmd_t   cmd_in;

  // classify the incoming beat
  always_comb begin
    cmd_in.is_read  = in_op_i;
    cmd_in.is_start = (in_byte_i == CharStart);
    cmd_in.is_lf    = (in_byte_i == CharLf);
    cmd_in.data     = in_byte_i;
    cmd_in.err      = in_err_i;
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rptr_q];

  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nsrf_back.sv =====
`default_nettype none

`include "nmea_sentence_ring_framer_core_assert.svh"

module nsrf_back
  import nsrf_pkg::*;
#(
  parameter int unsigned SLOTS       = SlotsDef,
  parameter int unsigned MSG_MAX_LEN = MsgMaxLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  nsrf_cmd_t cmd_i,
  output logic      cmd_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output nsrf_res_t out_o
);

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned LEN_W  = $clog2(MSG_MAX_LEN + 1);
  localparam int unsigned HALF   = (MSG_MAX_LEN + 1) / 2;
  localparam int unsigned PAIR_W = $clog2(HALF);
  localparam int unsigned DEPTH  = SLOTS * HALF;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_INFO  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_EMIT  = 4'b1000
  } nsrf_state_e;

  nsrf_state_e       state_q, state_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [SLOT_W-1:0] strm_slot_q, strm_slot_d;
  logic              full_q, full_d;
  logic              skip_q, skip_d;
  logic [LEN_W-1:0]  cur_len_q, cur_len_d;
  logic              cur_err_q, cur_err_d;
  logic [LEN_W-1:0]  rlen_q, rlen_d;
  logic              rerr_q, rerr_d;
  logic [PAIR_W-1:0] pair_q, pair_d;
  nsrf_res_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // byte store split into even and odd lanes, closed-slot length and error store
  logic [7:0]        mem_even [DEPTH];
  logic [7:0]        mem_odd  [DEPTH];
  logic [LEN_W:0]    info_mem [SLOTS];
  logic [7:0]        rd_even_q, rd_odd_q;
  logic [LEN_W:0]    info_rd_q;

  logic              out_free, out_load;
  logic              wr_en, mem_rd_en, info_wr_en, info_rd_en;
  logic [SLOT_W-1:0] wr_slot, wnext;
  logic [LEN_W-1:0]  wr_idx, close_len;
  logic              close_err;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              advance, carry, skip_eff;
  logic [LEN_W:0]    base, rem;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
    return n;
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign wr_addr = ADDR_W'(ADDR_W'(wr_slot) * ADDR_W'(HALF) + ADDR_W'(wr_idx >> 1));
  assign rd_addr = ADDR_W'(ADDR_W'(strm_slot_q) * ADDR_W'(HALF) + ADDR_W'(pair_q));
  assign base    = (LEN_W + 1)'({pair_q, 1'b0});
  assign rem     = {1'b0, rlen_q} - base;

  always_comb begin
    state_d     = state_q;
    wslot_d     = wslot_q;
    rslot_d     = rslot_q;
    strm_slot_d = strm_slot_q;
    full_d      = full_q;
    skip_d      = skip_q;
    cur_len_d   = cur_len_q;
    cur_err_d   = cur_err_q;
    rlen_d      = rlen_q;
    rerr_d      = rerr_q;
    pair_d      = pair_q;
    out_d       = out_q;
    out_load    = 1'b0;
    cmd_ready_o = 1'b0;
    wr_en       = 1'b0;
    wr_slot     = wslot_q;
    wr_idx      = cur_len_q;
    mem_rd_en   = 1'b0;
    info_wr_en  = 1'b0;
    info_rd_en  = 1'b0;
    close_len   = cur_len_q;
    close_err   = cur_err_q;
    advance     = 1'b0;
    carry       = 1'b0;
    skip_eff    = skip_q && !cmd_i.is_start;
    wnext       = next_slot(wslot_q);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          if (!cmd_i.is_read) begin
            if (!full_q) begin
              if (cmd_i.is_start) begin
                skip_d = 1'b0;
              end
              if (!skip_eff) begin
                priority if (cur_len_q >= LEN_W'(MSG_MAX_LEN)) begin
                  // overlong: close with error mark, byte discarded
                  advance   = 1'b1;
                  close_err = 1'b1;
                  skip_d    = 1'b1;
                end else if (!cmd_i.is_start && cur_len_q == '0) begin
                  skip_d = 1'b1;
                end else if (cmd_i.is_start && cur_len_q != '0) begin
                  // start mid-sentence closes the slot and carries over
                  advance = 1'b1;
                  carry   = 1'b1;
                end else begin
                  wr_en     = 1'b1;
                  cur_len_d = cur_len_q + 1'b1;
                  cur_err_d = cur_err_q | cmd_i.err;
                  close_len = cur_len_q + 1'b1;
                  close_err = cur_err_q | cmd_i.err;
                  advance   = cmd_i.is_lf;
                end
                if (advance) begin
                  info_wr_en = 1'b1;
                  wslot_d    = wnext;
                  cur_len_d  = '0;
                  cur_err_d  = 1'b0;
                  if (wnext == rslot_q) begin
                    full_d = 1'b1;
                  end else if (carry) begin
                    wr_en     = 1'b1;
                    wr_slot   = wnext;
                    wr_idx    = '0;
                    cur_len_d = LEN_W'(1);
                    cur_err_d = cmd_i.err;
                  end
                end
              end
            end
            out_load          = 1'b1;
            out_d             = '0;
            out_d.kind        = KIND_RX_STATUS;
            out_d.dropped     = full_q;
            out_d.full        = full_d;
            out_d.last        = 1'b1;
          end else if (!full_q && wslot_q == rslot_q) begin
            out_load   = 1'b1;
            out_d      = '0;
            out_d.kind = KIND_RING_EMPTY;
            out_d.last = 1'b1;
          end else begin
            // pop: look up length and error, free the slot
            info_rd_en  = 1'b1;
            strm_slot_d = rslot_q;
            rslot_d     = next_slot(rslot_q);
            full_d      = 1'b0;
            if (full_q) begin
              cur_len_d = '0;
              cur_err_d = 1'b0;
            end
            state_d = ST_INFO;
          end
        end
      end
      ST_INFO: begin
        rlen_d  = info_rd_q[LEN_W-1:0];
        rerr_d  = info_rd_q[LEN_W];
        pair_d  = '0;
        state_d = (info_rd_q[LEN_W-1:0] == '0) ? ST_EMIT : ST_FETCH;
      end
      ST_FETCH: begin
        mem_rd_en = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d           = '0;
          out_d.had_error = rerr_q;
          out_d.full      = full_q;
          if (rlen_q == '0) begin
            out_d.kind = KIND_EMPTY_SLOT;
            out_d.last = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            out_d.kind       = KIND_MSG_BYTES;
            out_d.msg_length = 8'(rlen_q);
            out_d.byte_first = rd_even_q;
            if (rem >= (LEN_W + 1)'(2)) begin
              out_d.bytes_here  = 2'd2;
              out_d.byte_second = rd_odd_q;
            end else begin
              out_d.bytes_here  = 2'd1;
            end
            out_d.last = (rem <= (LEN_W + 1)'(2));
            if (out_d.last) begin
              state_d = ST_IDLE;
            end else begin
              pair_d  = pair_q + 1'b1;
              state_d = ST_FETCH;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wslot_q     <= '0;
      rslot_q     <= '0;
      strm_slot_q <= '0;
      full_q      <= 1'b0;
      skip_q      <= 1'b0;
      cur_len_q   <= '0;
      cur_err_q   <= 1'b0;
      rlen_q      <= '0;
      rerr_q      <= 1'b0;
      pair_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wslot_q     <= wslot_d;
      rslot_q     <= rslot_d;
      strm_slot_q <= strm_slot_d;
      full_q      <= full_d;
      skip_q      <= skip_d;
      cur_len_q   <= cur_len_d;
      cur_err_q   <= cur_err_d;
      rlen_q      <= rlen_d;
      rerr_q      <= rerr_d;
      pair_q      <= pair_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_idx[0]) begin
      mem_even[wr_addr] <= cmd_i.data;
    end
    if (mem_rd_en) begin
      rd_even_q <= mem_even[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wr_idx[0]) begin
      mem_odd[wr_addr] <= cmd_i.data;
    end
    if (mem_rd_en) begin
      rd_odd_q <= mem_odd[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (info_wr_en) begin
      info_mem[wslot_q] <= {close_err, close_len};
    end
    if (info_rd_en) begin
      info_rd_q <= info_mem[rslot_q];
    end
  end

  `NSRF_ASSERT(full_means_caught_up, clk_i, rst_ni, full_q |-> (wslot_q == rslot_q))
  `NSRF_ASSERT(fetch_needs_length, clk_i, rst_ni, (state_q == ST_FETCH) |-> (rlen_q != '0))
  `NSRF_ASSERT(length_in_range, clk_i, rst_ni, cur_len_q <= LEN_W'(MSG_MAX_LEN))
  `NSRF_ASSERT(msg_beat_has_bytes, clk_i, rst_ni,
               (out_valid_q && out_q.kind == KIND_MSG_BYTES) |-> (out_q.bytes_here != 2'd0))
  `NSRF_ASSERT_NEXT(info_then_stream, clk_i, rst_ni, state_q == ST_INFO,
                    state_q == ST_FETCH || state_q == ST_EMIT)

endmodule

`default_nettype wire
